// ===== rtl/genetic_population_engine_macros.svh =====
// Assertion macros for the genetic population engine.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef GENETIC_POPULATION_ENGINE_MACROS_SVH
`define GENETIC_POPULATION_ENGINE_MACROS_SVH
`ifndef SYNTHESIS
`define GPE_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define GPE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define GPE_ASSERT(lbl, clk, rstn, prop, msg)
`define GPE_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ===== rtl/gpe_pkg.sv =====
// Shared constants and types for the genetic population engine.
// No dependencies.
package gpe_pkg;
  localparam int PopSize   = 16;
  localparam int GeneCount = 16;
  localparam int MaxGene   = 255;
  localparam int RowW  = $clog2(PopSize);
  localparam int GeneW = (GeneCount > 1) ? $clog2(GeneCount) : 1;
  localparam int GAddrW = RowW + GeneW;
  localparam int GDepth = PopSize * (1 << GeneW);

  typedef enum logic [2:0] {
    ACT_LOAD  = 3'd0,
    ACT_SETF  = 3'd1,
    ACT_SORT  = 3'd2,
    ACT_CROSS = 3'd3,
    ACT_MUT   = 3'd4,
    ACT_ELIM  = 3'd5,
    ACT_READ  = 3'd6,
    ACT_NONE  = 3'd7
  } action_t;

  typedef logic [RowW-1:0]  row_t;
  typedef logic [GeneW-1:0] gidx_t;
endpackage

// ===== rtl/gpe_ram.sv =====
// Generic single-port-write, single-read RAM with registered read.
// No dependencies.
module gpe_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ===== rtl/genetic_population_engine.sv =====
// Top level of the genetic population engine: sequencer plus gene and fitness RAMs.
// Depends on gpe_pkg, gpe_ram and genetic_population_engine_macros.svh.
//
// channel  ports                                   handshake
// in       in_action .. in_value_draw              start & !busy
// out      out_gene_out, out_fitness_out,
//          out_partner_used                        done (one cycle, no stall)
//
// Load, set fitness, a mutate that changes nothing and the unused code go
// straight to S_DONE; read passes S_READ, mutate S_MUT; eliminate walks the
// genes; crossover reduces the draw (quotient, then remainder), then walks them.
// Sort: each row pair is compared and swapped when the lower row is less fit;
// passes repeat until one makes no swap. Gene moves go through the single
// gene RAM port. No clearing pass after reset. Results cannot be stalled.
module genetic_population_engine (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_action,
  input  logic [3:0]  in_individual,
  input  logic [3:0]  in_gene_index,
  input  logic [7:0]  in_gene_in,
  input  logic signed [31:0] in_fitness_in,
  input  logic [15:0] in_partner_draw,
  input  logic [15:0] in_swap_mask,
  input  logic        in_mutate_flag,
  input  logic [15:0] in_position_draw,
  input  logic [15:0] in_value_draw,
  output logic        done,
  output logic [7:0]  out_gene_out,
  output logic signed [31:0] out_fitness_out,
  output logic [3:0]  out_partner_used
);
  import gpe_pkg::*;
  `include "genetic_population_engine_macros.svh"

  typedef enum logic [3:0] {
    S_IDLE, S_READ, S_READ2, S_MUT, S_ELIM, S_CROSS, S_SORT_RD, S_SORT_CMP,
    S_SWAP_FIT, S_SWAP_G, S_DONE
  } state_t;

  state_t state_r;
  logic [3:0]  row_r, gidx_r;
  logic [31:0] fin_r;
  logic [15:0] mask_r, pdraw_r;
  logic [15:0] posd_r, vald_r;
  row_t        partner_r;
  logic [GeneW:0] cnt_r;   // gene step counter, bit0 selects sub-step
  logic [1:0]  sub_r;
  row_t        srow_r;     // lower row of the compared pair
  logic        swapped_r;
  logic [7:0]  hold_r;
  logic [31:0] fa_r;
  logic [7:0]  gout_r;
  logic [31:0] fout_r;
  logic [3:0]  pout_r;
  logic        done_r;

  logic             g_we;
  logic [GAddrW-1:0] g_wa, g_ra;
  logic [7:0]       g_wd, g_rd;
  logic             f_we;
  row_t             f_wa, f_ra;
  logic [31:0]      f_wd, f_rd;

  gpe_ram #(.Width(8), .Depth(GDepth)) u_gene (
    .clk(clk), .we(g_we), .waddr(g_wa), .wdata(g_wd), .raddr(g_ra), .rdata(g_rd));
  gpe_ram #(.Width(32), .Depth(PopSize)) u_fit (
    .clk(clk), .we(f_we), .waddr(f_wa), .wdata(f_wd), .raddr(f_ra), .rdata(f_rd));

  function automatic logic [GAddrW-1:0] gaddr(input row_t r, input gidx_t g);
    return {r, g};
  endfunction

  localparam row_t LastRow = row_t'(PopSize - 1);
  localparam row_t PrevRow = row_t'(PopSize - 2);
  localparam gidx_t LastGene = gidx_t'(GeneCount - 1);
  localparam int PMod    = PopSize - 3;
  localparam int RecipSh = 24;
  // ceil(2^24 / PMod): floor division is exact for every 16-bit draw
  localparam logic [24:0] PRecip = 25'(((1 << RecipSh) + PMod - 1) / PMod);

  // partner = draw mod (PopSize-3) + 1 by reciprocal multiplication:
  // quotient registered first, then the remainder, before the gene walk.
  logic [15:0] quo_r;
  logic [1:0]  rcnt_r;
  logic [40:0] pprod;
  assign pprod = pdraw_r * PRecip;

  gidx_t gcur;
  assign gcur = cnt_r[GeneW:1];

  logic in_row_ok, in_gene_ok;
  assign in_row_ok  = ({1'b0, in_individual} < 5'(PopSize));
  assign in_gene_ok = ({1'b0, in_gene_index} < 5'(GeneCount));

  always_comb begin
    g_we = 1'b0; g_wa = '0; g_wd = '0; g_ra = '0;
    f_we = 1'b0; f_wa = '0; f_wd = '0; f_ra = '0;
    case (state_r)
      S_IDLE: begin
        g_ra = gaddr(row_t'(in_individual), gidx_t'(in_gene_index));
        f_ra = row_t'(in_individual);
        if (start) begin
          if (in_action == ACT_LOAD && in_row_ok && in_gene_ok) begin
            g_we = 1'b1;
            g_wa = gaddr(row_t'(in_individual), gidx_t'(in_gene_index));
            g_wd = in_gene_in;
          end
          if (in_action == ACT_SETF && in_row_ok) begin
            f_we = 1'b1; f_wa = row_t'(in_individual); f_wd = in_fitness_in;
          end
        end
      end
      S_MUT: begin
        g_we = 1'b1;
        g_wa = gaddr(row_t'(row_r), gidx_t'(posd_r % 16'(GeneCount)));
        g_wd = 8'(vald_r % 16'(MaxGene + 1));
      end
      S_ELIM: begin
        g_we = 1'b1;
        g_wa = gaddr(cnt_r[0] ? PrevRow : LastRow, gcur);
        f_we = (cnt_r == '0);
        f_wa = LastRow;
        if (sub_r == 2'd1) begin
          f_we = 1'b1; f_wa = PrevRow;
        end
      end
      S_CROSS: begin
        // sub 0: read row0[g]; sub 1: read partner[g]; sub 2: write LastRow;
        // sub 3: write PrevRow
        case (sub_r)
          2'd0: g_ra = gaddr('0, gcur);
          2'd1: g_ra = gaddr(partner_r, gcur);
          2'd2: begin
            g_we = 1'b1; g_wa = gaddr(LastRow, gcur);
            g_wd = mask_r[gcur] ? g_rd : fa_r[7:0];
          end
          default: begin
            g_we = 1'b1; g_wa = gaddr(PrevRow, gcur);
            g_wd = mask_r[gcur] ? fa_r[7:0] : hold_r;
          end
        endcase
      end
      S_SORT_RD: begin
        f_ra = sub_r[0] ? row_t'(srow_r + 1'b1) : srow_r;
      end
      S_SWAP_FIT: begin
        f_we = 1'b1;
        f_wa = sub_r[0] ? row_t'(srow_r + 1'b1) : srow_r;
        f_wd = sub_r[0] ? fa_r : fin_r;
      end
      S_SWAP_G: begin
        case (sub_r)
          2'd0: g_ra = gaddr(srow_r, gcur);
          2'd1: g_ra = gaddr(row_t'(srow_r + 1'b1), gcur);
          2'd2: begin
            g_we = 1'b1; g_wa = gaddr(srow_r, gcur); g_wd = g_rd;
          end
          default: begin
            g_we = 1'b1; g_wa = gaddr(row_t'(srow_r + 1'b1), gcur); g_wd = hold_r;
          end
        endcase
      end
      default: ;
    endcase
  end

  logic signed [31:0] fa_s, fb_s;
  assign fa_s = fa_r;
  assign fb_s = f_rd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      done_r  <= 1'b0;
      busy    <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (start) begin
            row_r <= in_individual; gidx_r <= in_gene_index;
            fin_r <= in_fitness_in;
            mask_r <= in_swap_mask; pdraw_r <= in_partner_draw;
            posd_r <= in_position_draw;
            vald_r <= in_value_draw;
            cnt_r <= '0; sub_r <= '0; srow_r <= '0; swapped_r <= 1'b0;
            gout_r <= '0; fout_r <= '0; pout_r <= '0;
            rcnt_r <= '0;
            busy <= 1'b1;
            case (in_action)
              ACT_READ:  state_r <= S_READ;
              ACT_MUT:   state_r <= (in_individual != 4'd0 && in_row_ok && in_mutate_flag)
                                    ? S_MUT : S_DONE;
              ACT_ELIM:  state_r <= S_ELIM;
              ACT_CROSS: state_r <= S_CROSS;
              ACT_SORT:  state_r <= S_SORT_RD;
              default:   state_r <= S_DONE;
            endcase
          end
        end
        S_READ: begin
          if ({1'b0, row_r} < 5'(PopSize)) begin
            fout_r <= f_rd;
            gout_r <= ({1'b0, gidx_r} < 5'(GeneCount)) ? g_rd : 8'd0;
          end
          state_r <= S_DONE;
        end
        S_MUT: state_r <= S_DONE;
        S_ELIM: begin
          sub_r <= 2'd0;
          if (cnt_r == '0) sub_r <= 2'd1;
          if (cnt_r[0] && gcur == LastGene) state_r <= S_DONE;
          else cnt_r <= cnt_r + 1'b1;
        end
        S_CROSS: begin
          if (rcnt_r != 2'd2) begin
            rcnt_r <= rcnt_r + 1'b1;
            if (rcnt_r == 2'd0) quo_r <= pprod[RecipSh+15:RecipSh];
            else partner_r <= row_t'(pdraw_r - 16'(quo_r * PMod)) + 1'b1;
          end else begin
            sub_r <= sub_r + 1'b1;
            if (sub_r == 2'd1) fa_r <= {24'd0, g_rd};      // row 0 gene
            if (sub_r == 2'd2) hold_r <= g_rd;             // partner gene
            if (sub_r == 2'd3) begin
              if (gcur == LastGene) begin
                pout_r <= 4'(partner_r);
                state_r <= S_DONE;
              end
              cnt_r <= cnt_r + 2'd2;
            end
          end
          if (rcnt_r != 2'd2) sub_r <= '0;
        end
        S_SORT_RD: begin
          sub_r <= sub_r + 1'b1;
          if (sub_r == 2'd1) fa_r <= f_rd;
          if (sub_r == 2'd1) state_r <= S_SORT_CMP;
        end
        S_SORT_CMP: begin
          sub_r <= '0;
          if (fa_s < fb_s) begin
            fin_r <= f_rd; swapped_r <= 1'b1; state_r <= S_SWAP_FIT;
          end else if (srow_r == PrevRow) begin
            srow_r <= '0; swapped_r <= 1'b0;
            state_r <= swapped_r ? S_SORT_RD : S_DONE;
          end else begin
            srow_r <= srow_r + 1'b1; state_r <= S_SORT_RD;
          end
        end
        S_SWAP_FIT: begin
          sub_r <= sub_r + 1'b1;
          if (sub_r[0]) begin
            sub_r <= '0; cnt_r <= '0; state_r <= S_SWAP_G;
          end
        end
        S_SWAP_G: begin
          sub_r <= sub_r + 1'b1;
          if (sub_r == 2'd1) hold_r <= g_rd;
          if (sub_r == 2'd3) begin
            cnt_r <= cnt_r + 2'd2;
            if (gcur == LastGene) begin
              sub_r <= '0;
              if (srow_r == PrevRow) begin
                srow_r <= '0; swapped_r <= 1'b0; state_r <= S_SORT_RD;
              end else begin
                srow_r <= srow_r + 1'b1; state_r <= S_SORT_RD;
              end
            end
          end
        end
        S_DONE: begin
          done_r <= 1'b1; busy <= 1'b0; state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign done = done_r;
  assign out_gene_out = gout_r;
  assign out_fitness_out = fout_r;
  assign out_partner_used = pout_r;

  `GPE_ASSERT(a_done_idle, clk, rst_n, done |-> !busy, "result while busy")
  `GPE_ASSERT(a_done_pulse, clk, rst_n, done |=> !done, "result strobe held")
  `GPE_ASSERT(a_start_busy, clk, rst_n, (start && !busy) |=> busy, "accept without busy")
  `GPE_ASSERT(a_partner_rng, clk, rst_n, done |-> (out_partner_used != LastRow),
              "partner out of range")
endmodule
